>>> hdl/uv_sphere_mesh_generator_unit_defines.svh
// Assertion macros used by the sphere generator controller
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/uvs_pkg.sv
// Types, constants and the sine table function of the sphere generator
`timescale 1ns / 1ps
package uvs_pkg;

    localparam int MAX_AXIAL_DEF       = 255;
    localparam int MAX_HEIGHT_DEF      = 256;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int IDX_W = 16;
    localparam int POS_W = 17;

    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [7:0]  AXIAL_RST  = 8'd16;
    localparam logic [8:0]  HEIGHT_RST = 9'd16;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_AXIAL  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic ITEM_VERTEX   = 1'b0;
    localparam logic ITEM_TRIANGLE = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        MS_DONE  = 3'd0,
        MS_RING  = 3'd1,
        MS_SOUTH = 3'd2,
        MS_NCAP  = 3'd3,
        MS_SIDE1 = 3'd4,
        MS_SIDE2 = 3'd5,
        MS_SCAP  = 3'd6
    } mesh_stage_t;

    typedef enum logic [3:0] {
        CS_FILL,
        CS_IDLE,
        CS_LK0,
        CS_LK1,
        CS_LK2,
        CS_LK3,
        CS_MUL0,
        CS_MUL1,
        CS_TRI,
        CS_OUT,
        CS_DIVP,
        CS_DIVP_WAIT,
        CS_DIVA,
        CS_DIVA_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OS_NORTH,
        OS_SOUTH,
        OS_RING,
        OS_TRI
    } out_sel_t;

    typedef struct packed {
        logic        fill_en;
        logic        latch;
        logic        div_start;
        logic        div_sel;
        logic        div_capture;
        logic        lk_en;
        logic [1:0]  lk_slot;
        logic        mul0;
        logic        mul1;
        logic        tri_base;
        logic        load_out;
        out_sel_t    out_sel;
        logic        advance;
    } uvs_cmd_t;

    typedef struct packed {
        logic        fill_last;
        logic        div_done;
        logic        out_free;
        mesh_stage_t stage;
    } uvs_status_t;

    // Reciprocal of the Taylor divisor (2n)(2n+1), scaled by 2^40 and rounded up;
    // exact floor division for any term below 2^32
    function automatic logic [63:0] taylor_recip(input int n);
        case (n)
            1:       return 64'd183251937963;
            2:       return 64'd54975581389;
            3:       return 64'd26178848281;
            4:       return 64'd15270994831;
            5:       return 64'd9995560253;
            6:       return 64'd7048151461;
            default: return 64'd5235769657;
        endcase
    endfunction

    // Quarter-wave sine entry k of a 2^bits table, Q1.15, by Taylor series in Q30
    function automatic logic [15:0] sine_entry(input int k, input int bits);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        logic [127:0] prod;
        int           n;
        x    = (64'(k) * HALF_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n < 8; n++)
        begin
            term = (term * x2) >> 30;
            prod = 128'(term) * 128'(taylor_recip(n));
            term = prod[103:40];
            if (n[0])
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[15:0];
    endfunction

endpackage

>>> hdl/uvs_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module uvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/uvs_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module uvs_div #(
    parameter int DVW = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [16:0]    dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [16:0]    quotient,
    output logic [DVW-1:0] remainder
);

    logic [DVW:0]   rem_reg, rem_next;
    logic [16:0]    quo_reg, quo_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DVW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DVW-1:0], quo_reg[16]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DVW-1:0];

endmodule

>>> hdl/uvs_datapath.sv
// Sphere generator datapath: registers, counters, lookups, multipliers, result
`timescale 1ns / 1ps
module uvs_datapath
    import uvs_pkg::*;
#(
    parameter int MAX_AXIAL       = MAX_AXIAL_DEF,
    parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  uvs_cmd_t                cmd,
    output uvs_status_t             status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    item_kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic [IDX_W-1:0]        corner_a,
    output logic [IDX_W-1:0]        corner_b,
    output logic [IDX_W-1:0]        corner_c,
    output logic                    last
);

    localparam int TB  = SINE_TABLE_BITS;
    localparam int N   = 1 << TB;
    localparam int AW  = $clog2(MAX_AXIAL + 1);
    localparam int SW  = $clog2(MAX_AXIAL + 2);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int DVW = (AW > HW) ? AW : HW;

    // configuration registers
    logic [15:0] radius_reg;
    logic [7:0]  axial_reg;
    logic [8:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            axial_reg  <= AXIAL_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_AXIAL:  axial_reg  <= cfg_data[7:0];
                CFG_HEIGHT: height_reg <= cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    // sine table fill
    logic [15:0]   rom [N];
    logic [TB-1:0] fill_cnt_reg;
    logic [TB-1:0] rd_addr;
    logic [15:0]   ram_q;

    for (genvar k = 0; k < N; k++)
    begin : g_rom
        assign rom[k] = sine_entry(k, TB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_cnt_reg <= '0;
        else if (cmd.fill_en)
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
    end

    uvs_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_sine_ram (
        .clk   (clk),
        .we    (cmd.fill_en),
        .waddr (fill_cnt_reg),
        .wdata (rom[fill_cnt_reg]),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // latched sphere parameters and walk state
    logic [AW-1:0]  lat_a_reg;
    logic [HW-1:0]  lat_h_reg;
    logic [15:0]    lat_r_reg;
    logic [15:0]    pol_q_reg, az_q_reg;
    logic [HW-1:0]  pol_r_reg;
    logic [AW-1:0]  az_r_reg;

    mesh_stage_t    stage_reg, stage_next;
    logic [HW-1:0]  ring_reg, ring_next;
    logic [AW-1:0]  seg_reg, seg_next;
    logic [15:0]    pphase_reg, pphase_next;
    logic [HW-1:0]  prem_reg, prem_next;
    logic [15:0]    aphase_reg, aphase_next;
    logic [AW-1:0]  arem_reg, arem_next;

    logic [AW-1:0]  clamp_a;
    logic [HW-1:0]  clamp_h;
    int             a_int, h_int;

    always_comb
    begin
        a_int = int'(axial_reg);
        h_int = int'(height_reg);
        if (a_int < 3)
            a_int = 3;
        if (a_int > MAX_AXIAL)
            a_int = MAX_AXIAL;
        if (h_int < 2)
            h_int = 2;
        if (h_int > MAX_HEIGHT)
            h_int = MAX_HEIGHT;
        clamp_a = AW'(a_int);
        clamp_h = HW'(h_int);
    end

    // divider for the phase steps
    logic           div_done;
    logic [16:0]    div_q;
    logic [DVW-1:0] div_r;
    logic [16:0]    div_dvd;
    logic [DVW-1:0] div_dvs;

    assign div_dvd = cmd.div_sel ? 17'd65536 : 17'd32768;
    assign div_dvs = cmd.div_sel ? DVW'(lat_a_reg) : DVW'(lat_h_reg);

    uvs_div #(
        .DVW (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            lat_a_reg <= clamp_a;
            lat_h_reg <= clamp_h;
            lat_r_reg <= radius_reg;
        end
        if (cmd.div_capture && !cmd.div_sel)
        begin
            pol_q_reg <= div_q[15:0];
            pol_r_reg <= HW'(div_r);
        end
        if (cmd.div_capture && cmd.div_sel)
        begin
            az_q_reg <= div_q[15:0];
            az_r_reg <= AW'(div_r);
        end
    end

    // walk advance
    logic [AW:0]   arem_sum;
    logic [HW:0]   prem_sum;
    logic [HW-1:0] ring_inc;
    logic [AW:0]   seg_inc;

    always_comb
    begin
        stage_next  = stage_reg;
        ring_next   = ring_reg;
        seg_next    = seg_reg;
        pphase_next = pphase_reg;
        prem_next   = prem_reg;
        aphase_next = aphase_reg;
        arem_next   = arem_reg;
        arem_sum    = {1'b0, arem_reg} + {1'b0, az_r_reg};
        prem_sum    = {1'b0, prem_reg} + {1'b0, pol_r_reg};
        ring_inc    = ring_reg + 1'b1;
        seg_inc     = {1'b0, seg_reg} + 1'b1;
        if (cmd.latch)
        begin
            stage_next  = MS_RING;
            ring_next   = HW'(1);
            seg_next    = '0;
            aphase_next = '0;
            arem_next   = '0;
        end
        else if (cmd.div_capture && !cmd.div_sel)
        begin
            pphase_next = div_q[15:0];
            prem_next   = HW'(div_r);
        end
        else if (cmd.advance)
        begin
            case (stage_reg)
                MS_RING:
                begin
                    seg_next = seg_inc[AW-1:0];
                    if (arem_sum >= {1'b0, lat_a_reg})
                    begin
                        arem_next   = AW'(arem_sum - {1'b0, lat_a_reg});
                        aphase_next = aphase_reg + az_q_reg + 16'd1;
                    end
                    else
                    begin
                        arem_next   = arem_sum[AW-1:0];
                        aphase_next = aphase_reg + az_q_reg;
                    end
                    if (seg_reg == lat_a_reg)
                    begin
                        seg_next    = '0;
                        aphase_next = '0;
                        arem_next   = '0;
                        ring_next   = ring_inc;
                        if (prem_sum >= {1'b0, lat_h_reg})
                        begin
                            prem_next   = HW'(prem_sum - {1'b0, lat_h_reg});
                            pphase_next = pphase_reg + pol_q_reg + 16'd1;
                        end
                        else
                        begin
                            prem_next   = prem_sum[HW-1:0];
                            pphase_next = pphase_reg + pol_q_reg;
                        end
                        if (ring_inc == lat_h_reg)
                            stage_next = MS_SOUTH;
                    end
                end
                MS_SOUTH:
                begin
                    seg_next   = AW'(1);
                    stage_next = MS_NCAP;
                end
                MS_NCAP:
                begin
                    seg_next = seg_inc[AW-1:0];
                    if (seg_reg == lat_a_reg)
                    begin
                        seg_next   = '0;
                        ring_next  = '0;
                        stage_next = (lat_h_reg > HW'(2)) ? MS_SIDE1 : MS_SCAP;
                    end
                end
                MS_SIDE1:
                begin
                    stage_next = MS_SIDE2;
                end
                MS_SIDE2:
                begin
                    stage_next = MS_SIDE1;
                    seg_next   = seg_inc[AW-1:0];
                    if (seg_inc >= {1'b0, lat_a_reg})
                    begin
                        seg_next  = '0;
                        ring_next = ring_inc;
                        if ({1'b0, ring_reg} + 1'b1 >= {1'b0, lat_h_reg} - 2'd2)
                            stage_next = MS_SCAP;
                    end
                end
                MS_SCAP:
                begin
                    seg_next = seg_inc[AW-1:0];
                    if (seg_inc >= {1'b0, lat_a_reg})
                        stage_next = MS_DONE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= MS_DONE;
            ring_reg   <= '0;
            seg_reg    <= '0;
            pphase_reg <= '0;
            prem_reg   <= '0;
            aphase_reg <= '0;
            arem_reg   <= '0;
        end
        else
        begin
            stage_reg  <= stage_next;
            ring_reg   <= ring_next;
            seg_reg    <= seg_next;
            pphase_reg <= pphase_next;
            prem_reg   <= prem_next;
            aphase_reg <= aphase_next;
            arem_reg   <= arem_next;
        end
    end

    // sine lookups: issue address, fold quadrant on the returning beat
    logic [15:0]        lk_phase;
    logic [TB-1:0]      lk_idx;
    logic               rd_valid_reg, rd_neg_reg, rd_full_reg;
    logic [1:0]         rd_slot_reg;
    logic signed [15:0] rd_val;
    logic signed [15:0] cos_p_reg, sin_p_reg, cos_a_reg, sin_a_reg;

    always_comb
    begin
        case (cmd.lk_slot)
            2'd0:    lk_phase = pphase_reg + 16'd16384;
            2'd1:    lk_phase = pphase_reg;
            2'd2:    lk_phase = aphase_reg + 16'd16384;
            default: lk_phase = aphase_reg;
        endcase
        lk_idx  = lk_phase[13 -: TB];
        rd_addr = lk_phase[14] ? (TB'(0) - lk_idx) : lk_idx;
        rd_val  = rd_full_reg ? 16'sd32767 : $signed(ram_q);
        if (rd_neg_reg)
            rd_val = -rd_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= cmd.lk_en;
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= cmd.lk_slot;
        rd_neg_reg  <= lk_phase[15];
        rd_full_reg <= lk_phase[14] && (lk_idx == '0);
        if (rd_valid_reg)
        begin
            case (rd_slot_reg)
                2'd0:    cos_p_reg <= rd_val;
                2'd1:    sin_p_reg <= rd_val;
                2'd2:    cos_a_reg <= rd_val;
                default: sin_a_reg <= rd_val;
            endcase
        end
    end

    // two multiply stages
    logic signed [32:0] rs_reg, yp_reg;
    logic signed [48:0] xp_reg, zp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul0)
        begin
            rs_reg <= $signed({1'b0, lat_r_reg}) * sin_p_reg;
            yp_reg <= $signed({1'b0, lat_r_reg}) * cos_p_reg;
        end
        if (cmd.mul1)
        begin
            xp_reg <= rs_reg * cos_a_reg;
            zp_reg <= rs_reg * sin_a_reg;
        end
    end

    // triangle base index
    logic [IDX_W-1:0] base_reg;
    logic [HW-1:0]    base_row;
    logic [SW-1:0]    wid;

    assign wid      = SW'(lat_a_reg) + 1'b1;
    assign base_row = (stage_reg == MS_SCAP) ? (lat_h_reg - 1'b1) : ring_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.tri_base)
            base_reg <= IDX_W'(32'd1 + 32'(base_row) * 32'(wid));
    end

    // result register
    logic                    ov_reg;
    logic                    kind_reg, last_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]        ca_reg, cb_reg, cc_reg;
    logic [IDX_W-1:0]        b_side, b_cap, w16, s16;
    logic [AW:0]             seg_inc1;

    assign w16      = IDX_W'(wid);
    assign s16      = IDX_W'(seg_reg);
    assign b_side   = base_reg + s16;
    assign b_cap    = base_reg - w16 + s16;
    assign seg_inc1 = {1'b0, seg_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.load_out)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg <= ITEM_VERTEX;
            last_reg <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
            pz_reg   <= '0;
            ca_reg   <= '0;
            cb_reg   <= '0;
            cc_reg   <= '0;
            case (cmd.out_sel)
                OS_NORTH: py_reg <= $signed({1'b0, lat_r_reg});
                OS_SOUTH: py_reg <= -$signed({1'b0, lat_r_reg});
                OS_RING:
                begin
                    px_reg <= POS_W'(xp_reg >>> 30);
                    py_reg <= POS_W'(yp_reg >>> 15);
                    pz_reg <= POS_W'(zp_reg >>> 30);
                end
                default:
                begin
                    kind_reg <= ITEM_TRIANGLE;
                    case (stage_reg)
                        MS_NCAP:
                        begin
                            cb_reg <= s16 + 1'b1;
                            cc_reg <= s16;
                        end
                        MS_SIDE1:
                        begin
                            ca_reg <= b_side;
                            cb_reg <= b_side + 1'b1;
                            cc_reg <= b_side + w16;
                        end
                        MS_SIDE2:
                        begin
                            ca_reg <= b_side + w16;
                            cb_reg <= b_side + 1'b1;
                            cc_reg <= b_side + w16 + 1'b1;
                        end
                        default:
                        begin
                            ca_reg   <= base_reg;
                            cb_reg   <= b_cap;
                            cc_reg   <= b_cap + 1'b1;
                            last_reg <= (seg_inc1 >= {1'b0, lat_a_reg});
                        end
                    endcase
                end
            endcase
        end
    end

    assign status.fill_last = (fill_cnt_reg == TB'(N - 1));
    assign status.div_done  = div_done;
    assign status.out_free  = !ov_reg || out_ready;
    assign status.stage     = stage_reg;

    assign out_valid = ov_reg;
    assign item_kind = kind_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign pos_z     = pz_reg;
    assign corner_a  = ca_reg;
    assign corner_b  = cb_reg;
    assign corner_c  = cc_reg;
    assign last      = last_reg;

endmodule

>>> hdl/uvs_ctrl.sv
// Sphere generator controller: sequences fill, division, lookups, multiplies and result beats
`timescale 1ns / 1ps
`include "uv_sphere_mesh_generator_unit_defines.svh"
module uvs_ctrl
    import uvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  uvs_status_t status,
    output uvs_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    out_sel_t    sel_reg, sel_next;
    logic        pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_FILL;
            sel_reg   <= OS_NORTH;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_ready   = (state_reg == CS_IDLE);
        case (state_reg)
            CS_FILL:
            begin
                cmd.fill_en = 1'b1;
                if (status.fill_last)
                    state_next = CS_IDLE;
            end
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        cmd.latch  = 1'b1;
                        sel_next   = OS_NORTH;
                        pend_next  = 1'b1;
                        state_next = CS_OUT;
                    end
                    else
                    begin
                        case (status.stage)
                            MS_RING:  state_next = CS_LK0;
                            MS_SOUTH:
                            begin
                                sel_next   = OS_SOUTH;
                                state_next = CS_OUT;
                            end
                            MS_NCAP, MS_SIDE1, MS_SIDE2, MS_SCAP:
                            begin
                                sel_next   = OS_TRI;
                                state_next = CS_TRI;
                            end
                            default:  state_next = CS_IDLE;
                        endcase
                    end
                end
            end
            CS_LK0:
            begin
                cmd.lk_en   = 1'b1;
                cmd.lk_slot = 2'd0;
                state_next  = CS_LK1;
            end
            CS_LK1:
            begin
                cmd.lk_en   = 1'b1;
                cmd.lk_slot = 2'd1;
                state_next  = CS_LK2;
            end
            CS_LK2:
            begin
                cmd.lk_en   = 1'b1;
                cmd.lk_slot = 2'd2;
                state_next  = CS_LK3;
            end
            CS_LK3:
            begin
                cmd.lk_en   = 1'b1;
                cmd.lk_slot = 2'd3;
                state_next  = CS_MUL0;
            end
            CS_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = CS_MUL1;
            end
            CS_MUL1:
            begin
                cmd.mul1   = 1'b1;
                sel_next   = OS_RING;
                state_next = CS_OUT;
            end
            CS_TRI:
            begin
                cmd.tri_base = 1'b1;
                state_next   = CS_OUT;
            end
            CS_OUT:
            begin
                cmd.out_sel = sel_reg;
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.advance  = (sel_reg != OS_NORTH);
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? CS_DIVP : CS_IDLE;
                end
            end
            CS_DIVP:
            begin
                cmd.div_start = 1'b1;
                state_next    = CS_DIVP_WAIT;
            end
            CS_DIVP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = CS_DIVA;
                end
            end
            CS_DIVA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = CS_DIVA_WAIT;
            end
            CS_DIVA_WAIT:
            begin
                cmd.div_sel = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    `UVS_ASSERT_NEXT(a_fill_once, state_reg != CS_FILL, state_reg != CS_FILL, "table fill re-entered")
    `UVS_ASSERT_IMPL(a_load_free, cmd.load_out, status.out_free, "result loaded over a pending beat")
    `UVS_ASSERT_IMPL(a_cap_done, cmd.div_capture, status.div_done, "divider captured early")
    `UVS_ASSERT_NEXT(a_done_idle, in_valid && in_ready && !restart && status.stage == MS_DONE, state_reg == CS_IDLE, "finished sphere left idle")

endmodule

>>> hdl/uv_sphere_mesh_generator_unit.sv
// UV sphere mesh generator: top level joining controller and datapath
//
// Request channel: in_valid/in_ready with restart. restart=1 latches radius,
// axial and height divisions and starts a sphere; restart=0 asks for the next
// item. Result channel: out_valid/out_ready carrying one vertex or triangle
// beat. Configuration: cfg_we/cfg_index/cfg_data, taken at any cycle, used at
// the next restart.
// Steps per item, set by the single sine table read port and the sequencer:
//   ring vertex: accept, four table reads, two multiply stages, load;
//   triangle: accept, base index, load; pole: accept, load; a request after
//   the final triangle is taken with no result. A restart runs the two
//   17-step divisions for the phase steps; requests are not taken meanwhile.
// After reset the sine table is filled, 2^SINE_TABLE_BITS entries, with
// in_ready low; no result is given until the first restart.
// A stalled receiver holds the result register; one further request can be
// taken and is worked up to its load, then waits for the register to drain.
`timescale 1ns / 1ps
module uv_sphere_mesh_generator_unit
    import uvs_pkg::*;
#(
    parameter int MAX_AXIAL       = MAX_AXIAL_DEF,
    parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    item_kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic [IDX_W-1:0]        corner_a,
    output logic [IDX_W-1:0]        corner_b,
    output logic [IDX_W-1:0]        corner_c,
    output logic                    last
);

    uvs_cmd_t    cmd;
    uvs_status_t status;

    uvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    uvs_datapath #(
        .MAX_AXIAL       (MAX_AXIAL),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item_kind (item_kind),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .last      (last)
    );

endmodule

>>> sim/uv_sphere_mesh_generator_unit_test.sv
// Self-checking testbench for the UV sphere mesh generator
`timescale 1ns / 1ps
module uv_sphere_mesh_generator_unit_test;
    import uvs_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int STALL_CYCLES = 400;
    localparam int SETTLE       = 20;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [IDX_W-1:0]        a;
        logic [IDX_W-1:0]        b;
        logic [IDX_W-1:0]        c;
        logic                    fin;
    } mesh_beat_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = CFG_RADIUS;
    logic [15:0]             cfg_data = 16'd0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    restart = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    item_kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic                    last;

    uv_sphere_mesh_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item_kind (item_kind),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .last      (last)
    );

    // Request queue, expected beats and run bookkeeping
    logic       request_q[$];
    mesh_beat_t expected_beats[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         stall_phase = 0;
    int         stall_count = 0;
    logic       stall_done = 1'b0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         vertex_count = 0;
    int         triangle_count = 0;
    int         sphere_count = 0;
    int         stim_items = 0;

    // Shadow of the registers and the generator state
    logic [15:0] reg_radius = RADIUS_RST;
    logic [7:0]  reg_axial = AXIAL_RST;
    logic [8:0]  reg_height = HEIGHT_RST;
    int unsigned lat_axial = 16, lat_height = 16, lat_radius = 256;
    mesh_stage_t gen_stage = MS_DONE;
    int unsigned ring_no = 0, seg_no = 0;
    logic [15:0] polar_ph = 16'd0, azim_ph = 16'd0;
    int unsigned polar_rem = 0, azim_rem = 0;
    int unsigned polar_step = 0, polar_frac = 0, azim_step = 0, azim_frac = 0;
    logic [15:0] quarter_wave[0:1023];

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] quarter_sine(input int unsigned k);
        logic [63:0] ang;
        logic [63:0] sq;
        logic [63:0] trm;
        logic [63:0] acc;
        int          n;
        ang = (64'(k) * 64'd1686629713) >> 10;
        sq  = (ang * ang) >> 30;
        trm = ang;
        acc = ang;
        for (n = 1; n < 8; n++)
        begin
            trm = (trm * sq) >> 30;
            trm = trm / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = (acc >= trm) ? acc - trm : 64'd0;
            else
                acc = acc + trm;
        end
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
            acc = 64'd32767;
        return acc[15:0];
    endfunction

    function automatic longint sine_of(input logic [15:0] ph);
        int unsigned idx;
        longint      v;
        idx = ph[13:4];
        if (ph[14])
            v = (idx == 0) ? 32767 : longint'(quarter_wave[1024 - idx]);
        else
            v = longint'(quarter_wave[idx]);
        return ph[15] ? -v : v;
    endfunction

    function automatic longint cosine_of(input logic [15:0] ph);
        return sine_of(ph + 16'd16384);
    endfunction

    function automatic int unsigned clamp_axial(input logic [7:0] v);
        return (v < 3) ? 3 : v;
    endfunction

    function automatic int unsigned clamp_height(input logic [8:0] v);
        if (v < 2)
            return 2;
        return (v > 256) ? 256 : v;
    endfunction

    // Work out the beat (if any) that one accepted request gives
    task automatic predict_request(input logic rst_bit);
        mesh_beat_t  bt;
        logic        got;
        int unsigned w;
        int unsigned s;
        int unsigned b;
        longint      rs;
        bt  = '0;
        got = 1'b1;
        w   = lat_axial + 1;
        s   = 1 + (lat_height - 1) * w;
        if (rst_bit)
        begin
            lat_axial  = clamp_axial(reg_axial);
            lat_height = clamp_height(reg_height);
            lat_radius = reg_radius;
            polar_step = 32768 / lat_height;
            polar_frac = 32768 % lat_height;
            azim_step  = 65536 / lat_axial;
            azim_frac  = 65536 % lat_axial;
            polar_ph   = polar_step[15:0];
            polar_rem  = polar_frac;
            azim_ph    = 16'd0;
            azim_rem   = 0;
            ring_no    = 1;
            seg_no     = 0;
            gen_stage  = MS_RING;
            bt.kind    = ITEM_VERTEX;
            bt.y       = POS_W'(lat_radius);
        end
        else
        begin
            case (gen_stage)
                MS_RING:
                begin
                    rs      = longint'(lat_radius) * sine_of(polar_ph);
                    bt.kind = ITEM_VERTEX;
                    bt.y    = POS_W'((longint'(lat_radius) * cosine_of(polar_ph)) >>> 15);
                    bt.x    = POS_W'((rs * cosine_of(azim_ph)) >>> 30);
                    bt.z    = POS_W'((rs * sine_of(azim_ph)) >>> 30);
                    seg_no++;
                    azim_ph  = azim_ph + azim_step[15:0];
                    azim_rem = azim_rem + azim_frac;
                    if (azim_rem >= lat_axial)
                    begin
                        azim_rem = azim_rem - lat_axial;
                        azim_ph  = azim_ph + 16'd1;
                    end
                    if (seg_no > lat_axial)
                    begin
                        seg_no    = 0;
                        azim_ph   = 16'd0;
                        azim_rem  = 0;
                        ring_no++;
                        polar_ph  = polar_ph + polar_step[15:0];
                        polar_rem = polar_rem + polar_frac;
                        if (polar_rem >= lat_height)
                        begin
                            polar_rem = polar_rem - lat_height;
                            polar_ph  = polar_ph + 16'd1;
                        end
                        if (ring_no > lat_height - 1)
                            gen_stage = MS_SOUTH;
                    end
                end
                MS_SOUTH:
                begin
                    bt.kind   = ITEM_VERTEX;
                    bt.y      = POS_W'(-longint'(lat_radius));
                    seg_no    = 1;
                    gen_stage = MS_NCAP;
                end
                MS_NCAP:
                begin
                    bt.kind = ITEM_TRIANGLE;
                    bt.b    = IDX_W'(seg_no + 1);
                    bt.c    = IDX_W'(seg_no);
                    seg_no++;
                    if (seg_no > lat_axial)
                    begin
                        seg_no    = 0;
                        ring_no   = 0;
                        gen_stage = (lat_height > 2) ? MS_SIDE1 : MS_SCAP;
                    end
                end
                MS_SIDE1:
                begin
                    b         = 1 + ring_no * w + seg_no;
                    bt.kind   = ITEM_TRIANGLE;
                    bt.a      = IDX_W'(b);
                    bt.b      = IDX_W'(b + 1);
                    bt.c      = IDX_W'(b + w);
                    gen_stage = MS_SIDE2;
                end
                MS_SIDE2:
                begin
                    b         = 1 + ring_no * w + seg_no;
                    bt.kind   = ITEM_TRIANGLE;
                    bt.a      = IDX_W'(b + w);
                    bt.b      = IDX_W'(b + 1);
                    bt.c      = IDX_W'(b + w + 1);
                    gen_stage = MS_SIDE1;
                    seg_no++;
                    if (seg_no >= lat_axial)
                    begin
                        seg_no = 0;
                        ring_no++;
                        if (ring_no >= lat_height - 2)
                            gen_stage = MS_SCAP;
                    end
                end
                MS_SCAP:
                begin
                    b       = s - w + seg_no;
                    bt.kind = ITEM_TRIANGLE;
                    bt.a    = IDX_W'(s);
                    bt.b    = IDX_W'(b);
                    bt.c    = IDX_W'(b + 1);
                    bt.fin  = (seg_no + 1 >= lat_axial);
                    seg_no++;
                    if (seg_no >= lat_axial)
                        gen_stage = MS_DONE;
                end
                default:
                    got = 1'b0;
            endcase
        end
        if (got)
            expected_beats.insert(expected_beats.size(), bt);
    endtask

    // Driver: offer queued requests, predict on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(restart);
            if (!in_valid || in_ready)
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= request_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here while the stall phase runs
    always @(posedge clk)
    begin
        if (stall_phase != 0 && !stall_done)
        begin
            stall_count <= stall_count + 1;
            if (stall_count == STALL_CYCLES)
                stall_done <= 1'b1;
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        mesh_beat_t want;
        mesh_beat_t seen;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = '{item_kind, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, last};
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat %h", seen);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.kind == ITEM_VERTEX)
                        vertex_count++;
                    else
                        triangle_count++;
                    if (want.fin)
                        sphere_count++;
                    if (seen.kind !== want.kind || seen.x !== want.x || seen.y !== want.y
                        || seen.z !== want.z || seen.a !== want.a || seen.b !== want.b
                        || seen.c !== want.c || seen.fin !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch (exp/act): kind %0d/%0d last %0d/%0d",
                                     want.kind, seen.kind, want.fin, seen.fin);
                            $display("  xyz %0d,%0d,%0d / %0d,%0d,%0d",
                                     want.x, want.y, want.z, seen.x, seen.y, seen.z);
                            $display("  abc %0d,%0d,%0d / %0d,%0d,%0d",
                                     want.a, want.b, want.c, seen.a, seen.b, seen.c);
                        end
                    end
                end
            end
            out_ready <= !(stall_phase != 0 && !stall_done)
                         && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("uv_sphere_mesh_generator_unit_test failed");
            $finish;
        end
    end

    task automatic drain;
        @(negedge clk);
        while (request_q.size() > 0 || in_valid || expected_beats.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RADIUS)
            reg_radius = val;
        else if (idx == CFG_AXIAL)
            reg_axial = val[7:0];
        else
            reg_height = val[8:0];
    endtask

    task automatic push_requests(input logic first_restart, input int n);
        int i;
        if (first_restart)
            request_q.insert(request_q.size(), 1'b1);
        for (i = 0; i < n; i++)
            request_q.insert(request_q.size(), 1'b0);
        stim_items += n + first_restart;
    endtask

    task automatic random_config;
        int pick;
        pick = $urandom_range(9);
        write_reg(CFG_RADIUS, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF : 16'($urandom));
        pick = $urandom_range(9);
        write_reg(CFG_AXIAL, pick == 0 ? 16'd255 : pick == 1 ? 16'($urandom_range(255))
                             : 16'($urandom_range(0, 10)));
        pick = $urandom_range(9);
        write_reg(CFG_HEIGHT, pick == 0 ? 16'($urandom_range(256, 511))
                              : pick == 1 ? 16'($urandom_range(511))
                              : 16'($urandom_range(0, 8)));
    endtask

    initial
    begin
        int          full_len;
        int          n;
        int          cut;
        int          i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (i = 0; i < 1024; i++)
            quarter_wave[i] = quarter_sine(i);

        // Directed: smallest clamped sphere at full radius, run past its end
        push_requests(1'b0, 1);
        drain();
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_AXIAL, 16'd0);
        write_reg(CFG_HEIGHT, 16'd0);
        push_requests(1'b1, 13);
        drain();
        // Largest divisions, zero radius, abandoned mid-sphere
        write_reg(CFG_RADIUS, 16'd0);
        write_reg(CFG_AXIAL, 16'd255);
        write_reg(CFG_HEIGHT, 16'h1FF);
        push_requests(1'b1, 4);
        drain();
        // Change the registers mid-sphere: no effect until the next restart
        write_reg(CFG_RADIUS, 16'd256);
        write_reg(CFG_AXIAL, 16'd3);
        write_reg(CFG_HEIGHT, 16'd1);
        push_requests(1'b0, 2);
        push_requests(1'b1, 3);
        drain();

        // Fill the block against a held receiver
        write_reg(CFG_AXIAL, 16'd16);
        write_reg(CFG_HEIGHT, 16'd16);
        stall_phase = 1;
        push_requests(1'b1, 80);
        drain();
        stall_phase = 0;

        while (stim_items < 1650)
        begin
            if (stim_items < 550)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 80;
            end
            else if (stim_items < 1100)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            full_len = 2 + (clamp_height(reg_height) - 1) * (clamp_axial(reg_axial) + 1)
                       + 2 * clamp_axial(reg_axial) * (clamp_height(reg_height) - 1) - 1;
            if (full_len > 200)
                full_len = $urandom_range(10, 200);
            case ($urandom_range(9))
                0:
                begin
                    // noise: random mix of restarts and requests
                    n = $urandom_range(5, 30);
                    for (i = 0; i < n; i++)
                        request_q.insert(request_q.size(), $urandom_range(7) == 0);
                    stim_items += n;
                end
                1, 2:
                    push_requests(1'b1, $urandom_range(1, full_len));
                3:
                begin
                    // registers rewritten partway through a sphere
                    cut = $urandom_range(1, full_len);
                    push_requests(1'b1, cut);
                    drain();
                    random_config();
                    push_requests(1'b0, full_len - cut + $urandom_range(3));
                end
                default:
                    push_requests(1'b1, full_len + $urandom_range(3));
            endcase
            drain();
        end

        drain();
        $display("run covered %0d request beats: %0d vertices, %0d triangles",
                 stim_items, vertex_count, triangle_count);
        $display("%0d whole spheres, %0d mismatches over %0d cycles",
                 sphere_count, mismatches, cycle_count);
        if (mismatches == 0)
            $display("uv_sphere_mesh_generator_unit_test passed");
        else
            $display("uv_sphere_mesh_generator_unit_test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/uvs_pkg.sv
hdl/uvs_ram.sv
hdl/uvs_div.sv
hdl/uvs_datapath.sv
hdl/uvs_ctrl.sv
hdl/uv_sphere_mesh_generator_unit.sv
sim/uv_sphere_mesh_generator_unit_test.sv
